FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITFFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITFFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: sv/itffa_pkg.sv
// ----------------------------------------------------------------------------
// itffa_pkg
// Types and constants of the first-fit interval tag allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itffa_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_OUT
  } state_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_EXISTING = 3'd0,
    ST_NEW      = 3'd1,
    ST_CLEARED  = 3'd2,
    ST_NO_TAG   = 3'd3,
    ST_FULL     = 3'd4,
    ST_ORDER    = 3'd5
  } status_e;

  // Item kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Configuration register map (word index).
  localparam logic REG_TAG_LIMIT = 1'b0;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] TAG_LIMIT_RESET = 5'd8;

  // Intervals whose last stage minus first stage is below this never conflict.
  localparam int unsigned MIN_SPAN = 2;

endpackage

`default_nettype wire

FILE: sv/interval_tag_first_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// interval_tag_first_fit_allocator_unit
// First-fit tag allocator for stage intervals with a stored interval table.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per beat: an allocate item (kind 0)
//   with first stage, last stage and thread, or a clear item (kind 1). The
//   output channel carries one result beat per item: tag, status, tag count
//   and the over-limit flag. tag_limit is written over the APB port.
// Sequencing:
//   Clear items and items rejected for stage order or a full store offer
//   their result in the cycle after the accepting edge. An allocate item
//   scans every stored interval through one shared conflict comparator,
//   one entry per cycle out of the interval memory, then walks the open
//   tags one per cycle to find the lowest free one, or else opens a new
//   tag if any is left. The next item is taken only once the result beat
//   has been accepted; in_stall_o is high from the accepting edge until then.
// Reset:
//   Empties the store, closes all tags and sets tag_limit to 8. The memory
//   itself is not cleared; only entries below the fill count are read.
// Stall:
//   While out_stall_i is high the result beat holds and no item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interval_tag_first_fit_allocator_unit #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned MAX_TAGS    = 16,
  parameter int unsigned STAGE_BITS  = 5
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // APB configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [itffa_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [itffa_pkg::DATA_W-1:0]         pwdata,
  output logic      [itffa_pkg::DATA_W-1:0]         prdata,
  output logic                                      pready,
  // Input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 kind_i,
  input  wire logic [STAGE_BITS-1:0]                first_stage_i,
  input  wire logic [STAGE_BITS-1:0]                last_stage_i,
  input  wire logic [1:0]                           thread_id_i,
  // Output channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic      [$clog2(MAX_TAGS)-1:0]          tag_o,
  output logic      [2:0]                           status_o,
  output logic      [$clog2(MAX_TAGS+1)-1:0]        tag_count_o,
  output logic                                      over_limit_o
);

  import itffa_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TGW = $clog2(MAX_TAGS);
  localparam int unsigned TCW = $clog2(MAX_TAGS + 1);
  localparam int unsigned LW  = (TCW > LIMIT_W) ? TCW : LIMIT_W;
  localparam int unsigned EW  = 2 * STAGE_BITS + 2 + TGW;

  // Entry word layout: {first, last, thread, tag}.
  localparam int unsigned TAG_LSB    = 0;
  localparam int unsigned THREAD_LSB = TGW;
  localparam int unsigned LAST_LSB   = TGW + 2;
  localparam int unsigned FIRST_LSB  = TGW + 2 + STAGE_BITS;

  state_e                 state_q, state_d;
  logic [STAGE_BITS-1:0]  first_q, first_d;
  logic [STAGE_BITS-1:0]  last_q, last_d;
  logic [1:0]             thread_q, thread_d;
  logic [CW-1:0]          entry_count_q, entry_count_d;
  logic [TCW-1:0]         tags_open_q, tags_open_d;
  logic [LIMIT_W-1:0]     tag_limit_q;
  logic [CW-1:0]          rd_idx_q, rd_idx_d;
  logic                   rvalid_q, rvalid_d;
  logic [MAX_TAGS-1:0]    busy_q, busy_d;
  logic [TCW-1:0]         pick_q, pick_d;
  logic [TGW-1:0]         res_tag_q, res_tag_d;
  logic [2:0]             res_status_q, res_status_d;
  logic [TCW-1:0]         res_count_q, res_count_d;

  logic [EW-1:0]          entry_mem_q [MAX_ENTRIES];
  logic [EW-1:0]          rd_data_q;
  logic                   mem_we, mem_re;
  logic [EW-1:0]          wr_data;

  logic [STAGE_BITS-1:0]  rd_first, rd_last;
  logic [1:0]             rd_thread;
  logic [TGW-1:0]         rd_tag;
  logic                   short_span, hit;
  logic                   cfg_sel, cfg_we;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_sel = (paddr[ADDR_W-1] == REG_TAG_LIMIT);
  assign cfg_we  = psel && penable && pwrite && pready && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? DATA_W'(tag_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_limit_q <= TAG_LIMIT_RESET;
    end else if (cfg_we) begin
      tag_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Interval memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  assign wr_data = {first_q, last_q, thread_q, pick_q[TGW-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[entry_count_q[AW-1:0]] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= entry_mem_q[rd_idx_q[AW-1:0]];
    end
  end

  assign rd_first  = rd_data_q[FIRST_LSB +: STAGE_BITS];
  assign rd_last   = rd_data_q[LAST_LSB +: STAGE_BITS];
  assign rd_thread = rd_data_q[THREAD_LSB +: 2];
  assign rd_tag    = rd_data_q[TAG_LSB +: TGW];

  // Shared conflict comparator. Both intervals are well ordered here, so the
  // span subtractions cannot wrap.
  assign short_span = ((last_q - first_q) < STAGE_BITS'(MIN_SPAN)) ||
                      ((rd_last - rd_first) < STAGE_BITS'(MIN_SPAN));

  always_comb begin
    if (short_span) begin
      hit = 1'b0;
    end else if (thread_q == rd_thread) begin
      hit = !((first_q >= rd_last) || (last_q <= rd_first));
    end else begin
      hit = !((first_q > rd_last) || (last_q < rd_first));
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      entry_count_q <= '0;
      tags_open_q   <= '0;
      rd_idx_q      <= '0;
      rvalid_q      <= 1'b0;
      busy_q        <= '0;
      pick_q        <= '0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      tags_open_q   <= tags_open_d;
      rd_idx_q      <= rd_idx_d;
      rvalid_q      <= rvalid_d;
      busy_q        <= busy_d;
      pick_q        <= pick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q      <= first_d;
    last_q       <= last_d;
    thread_q     <= thread_d;
    res_tag_q    <= res_tag_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
  end

  always_comb begin
    state_d       = state_q;
    first_d       = first_q;
    last_d        = last_q;
    thread_d      = thread_q;
    entry_count_d = entry_count_q;
    tags_open_d   = tags_open_q;
    rd_idx_d      = rd_idx_q;
    rvalid_d      = rvalid_q;
    busy_d        = busy_q;
    pick_d        = pick_q;
    res_tag_d     = res_tag_q;
    res_status_d  = res_status_q;
    res_count_d   = res_count_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          first_d      = first_stage_i;
          last_d       = last_stage_i;
          thread_d     = thread_id_i;
          rd_idx_d     = '0;
          rvalid_d     = 1'b0;
          busy_d       = '0;
          pick_d       = '0;
          res_tag_d    = '0;
          res_count_d  = tags_open_q;
          if (kind_i == KIND_CLEAR) begin
            entry_count_d = '0;
            tags_open_d   = '0;
            res_status_d  = ST_CLEARED;
            res_count_d   = '0;
            state_d       = S_OUT;
          end else if (first_stage_i > last_stage_i) begin
            res_status_d = ST_ORDER;
            state_d      = S_OUT;
          end else if (entry_count_q == CW'(MAX_ENTRIES)) begin
            res_status_d = ST_FULL;
            state_d      = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle while the previous word goes through the
        // comparator.
        if (rd_idx_q != entry_count_q) begin
          mem_re   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
          rvalid_d = 1'b1;
        end else begin
          rvalid_d = 1'b0;
        end
        if (rvalid_q && hit) begin
          busy_d[rd_tag] = 1'b1;
        end
        if ((rd_idx_q == entry_count_q) && !rvalid_q) begin
          state_d = S_PICK;
        end
      end

      S_PICK: begin
        if (pick_q == tags_open_q) begin
          if (tags_open_q == TCW'(MAX_TAGS)) begin
            res_tag_d    = '0;
            res_status_d = ST_NO_TAG;
            res_count_d  = tags_open_q;
          end else begin
            mem_we        = 1'b1;
            entry_count_d = entry_count_q + 1'b1;
            tags_open_d   = tags_open_q + 1'b1;
            res_tag_d     = pick_q[TGW-1:0];
            res_status_d  = ST_NEW;
            res_count_d   = tags_open_q + 1'b1;
          end
          state_d = S_OUT;
        end else if (!busy_q[pick_q[TGW-1:0]]) begin
          mem_we        = 1'b1;
          entry_count_d = entry_count_q + 1'b1;
          res_tag_d     = pick_q[TGW-1:0];
          res_status_d  = ST_EXISTING;
          res_count_d   = tags_open_q;
          state_d       = S_OUT;
        end else begin
          pick_d = pick_q + 1'b1;
        end
      end

      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign tag_o        = res_tag_q;
  assign status_o     = res_status_q;
  assign tag_count_o  = res_count_q;
  assign over_limit_o = (LW'(res_count_q) >= LW'(tag_limit_q));

endmodule

`default_nettype wire

FILE: sv/itffa_checker.sv
// ----------------------------------------------------------------------------
// itffa_checker
// Port-level checks of the first-fit interval tag allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itffa_checker #(
  parameter int unsigned MAX_TAGS = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [$clog2(MAX_TAGS)-1:0]   tag_o,
  input wire logic [2:0]                    status_o,
  input wire logic [$clog2(MAX_TAGS+1)-1:0] tag_count_o
);

  import itffa_pkg::*;

  localparam int unsigned TCW = $clog2(MAX_TAGS + 1);

  logic           new_beat;
  logic [TCW-1:0] tag_next;
  logic           tagless_beat;
  logic           tagless_ok;

  assign new_beat     = out_valid_o && (status_o == ST_NEW);
  assign tag_next     = TCW'(tag_o) + TCW'(1);
  assign tagless_beat = out_valid_o && ((status_o == ST_CLEARED) || (status_o == ST_NO_TAG) ||
                        (status_o == ST_FULL) || (status_o == ST_ORDER));
  assign tagless_ok   = (tag_o == '0) && ((status_o != ST_CLEARED) || (tag_count_o == '0));

  // A result beat that is stalled stays offered.
  `ITFFA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Only one item is in flight: no item is taken while a result is pending.
  `ITFFA_ASSERT_IMP(a_busy_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)

  // Taking an item closes the input side on the next cycle.
  `ITFFA_ASSERT_NXT(a_stall_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A newly opened tag is always the highest one in use.
  `ITFFA_ASSERT_IMP(a_new_tag_top, clk_i, rst_ni, new_beat, tag_count_o == tag_next)

  // Cleared and rejected items carry tag 0; a clear leaves no tag open.
  `ITFFA_ASSERT_IMP(a_no_tag, clk_i, rst_ni, tagless_beat, tagless_ok)

endmodule

bind interval_tag_first_fit_allocator_unit itffa_checker #(
  .MAX_TAGS(MAX_TAGS)
) u_itffa_checker (.*);

`default_nettype wire

FILE: bench/tb_interval_tag_first_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_interval_tag_first_fit_allocator_unit
// Self-checking bench for the first-fit interval tag allocator.
// A short table of hand-picked intervals comes first. Then come bursts of
// random intervals in several traffic phases, with a new tag_limit written
// over APB between phases. Every accepted item is run through a first-fit
// predictor that keeps its own copy of the interval store. The result beats
// are checked field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_interval_tag_first_fit_allocator_unit;
  import itffa_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int TAG_SLOTS    = 16;
  localparam int PHASE_BEATS  = 130;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic       kind;
    logic [4:0] first_stg;
    logic [4:0] last_stg;
    logic [1:0] thread;
  } interval_req_t;

  typedef struct packed {
    logic [3:0] tag;
    status_e    status;
    logic [4:0] count;
    logic       over;
  } alloc_res_t;

  typedef struct packed {
    interval_req_t req;
    logic          fixed;
    alloc_res_t    want;
  } plan_row_t;

  typedef enum {
    BURST_WIDE,
    BURST_ORDERED,
    BURST_SHORT,
    BURST_MIXED
  } burst_e;

  localparam alloc_res_t NO_WANT = '{4'd0, ST_EXISTING, 5'd0, 1'b0};

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                kind_i;
  logic [4:0]          first_stage_i;
  logic [4:0]          last_stage_i;
  logic [1:0]          thread_id_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [3:0]          tag_o;
  logic [2:0]          status_o;
  logic [4:0]          tag_count_o;
  logic                over_limit_o;

  interval_tag_first_fit_allocator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .first_stage_i (first_stage_i),
    .last_stage_i  (last_stage_i),
    .thread_id_i   (thread_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tag_o         (tag_o),
    .status_o      (status_o),
    .tag_count_o   (tag_count_o),
    .over_limit_o  (over_limit_o)
  );

  // Shadow of the block's interval store and tag state.
  logic [4:0] shadow_first [STORE_DEPTH];
  logic [4:0] shadow_last  [STORE_DEPTH];
  logic [1:0] shadow_thread[STORE_DEPTH];
  logic [3:0] shadow_tag   [STORE_DEPTH];
  int         shadow_count;
  int         shadow_tags;
  logic [4:0] shadow_limit;

  alloc_res_t expected_allocs[$];
  int         mismatches;
  int         stall_pct;
  int         hold_left;
  int         stage_cursor;
  logic       drv_fixed;
  alloc_res_t drv_want;

  plan_row_t plan [0:18] = '{
    '{'{KIND_ALLOC, 5'd0,  5'd31, 2'd0}, 1'b1, '{4'd0, ST_NEW,      5'd1, 1'b0}},
    '{'{KIND_ALLOC, 5'd0,  5'd31, 2'd0}, 1'b1, '{4'd1, ST_NEW,      5'd2, 1'b0}},
    '{'{KIND_ALLOC, 5'd31, 5'd0,  2'd0}, 1'b1, '{4'd0, ST_ORDER,    5'd2, 1'b0}},
    '{'{KIND_ALLOC, 5'd5,  5'd5,  2'd3}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd0,  5'd1,  2'd2}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd31, 5'd31, 2'd1}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd0,  5'd2,  2'd1}, 1'b0, NO_WANT},
    '{'{KIND_CLEAR, 5'd31, 5'd0,  2'd3}, 1'b1, '{4'd0, ST_CLEARED,  5'd0, 1'b0}},
    '{'{KIND_ALLOC, 5'd4,  5'd8,  2'd0}, 1'b1, '{4'd0, ST_NEW,      5'd1, 1'b0}},
    '{'{KIND_ALLOC, 5'd8,  5'd12, 2'd0}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd12, 5'd16, 2'd1}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd14, 5'd20, 2'd1}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd17, 5'd22, 2'd3}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd0,  5'd31, 2'd3}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd20, 5'd24, 2'd2}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd31, 5'd31, 2'd2}, 1'b0, NO_WANT},
    '{'{KIND_ALLOC, 5'd0,  5'd0,  2'd0}, 1'b0, NO_WANT},
    '{'{KIND_CLEAR, 5'd0,  5'd0,  2'd0}, 1'b1, '{4'd0, ST_CLEARED,  5'd0, 1'b0}},
    '{'{KIND_ALLOC, 5'd30, 5'd31, 2'd3}, 1'b0, NO_WANT}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit intervals_clash(int af, int al, int at, int bf, int bl, int bt);
    if (al - af < int'(MIN_SPAN) || bl - bf < int'(MIN_SPAN)) return 1'b0;
    // Same thread compares open ranges, different threads closed ranges.
    if (at == bt) return !(af >= bl || al <= bf);
    return !(af > bl || al < bf);
  endfunction

  function automatic alloc_res_t first_fit(interval_req_t r);
    alloc_res_t           res;
    logic [TAG_SLOTS-1:0] busy;
    int                   i;
    int                   t;
    res = NO_WANT;
    busy = '0;
    if (r.kind == KIND_CLEAR) begin
      shadow_count = 0;
      shadow_tags = 0;
      res.status = ST_CLEARED;
    end else if (r.first_stg > r.last_stg) begin
      res.status = ST_ORDER;
    end else if (shadow_count >= STORE_DEPTH) begin
      res.status = ST_FULL;
    end else begin
      for (i = 0; i < shadow_count; i++) begin
        if (intervals_clash(r.first_stg, r.last_stg, r.thread,
                            shadow_first[i], shadow_last[i], shadow_thread[i]))
          busy[shadow_tag[i]] = 1'b1;
      end
      t = 0;
      while (t < shadow_tags && busy[t]) t++;
      if (t < shadow_tags) begin
        res.status = ST_EXISTING;
      end else if (shadow_tags >= TAG_SLOTS) begin
        res.status = ST_NO_TAG;
      end else begin
        res.status = ST_NEW;
        shadow_tags++;
      end
      if (res.status != ST_NO_TAG) begin
        shadow_first[shadow_count] = r.first_stg;
        shadow_last[shadow_count] = r.last_stg;
        shadow_thread[shadow_count] = r.thread;
        shadow_tag[shadow_count] = 4'(t);
        shadow_count++;
        res.tag = 4'(t);
      end
    end
    res.count = 5'(shadow_tags);
    res.over = (shadow_tags >= int'(shadow_limit));
    return res;
  endfunction

  function automatic interval_req_t make_interval(burst_e m, bit noisy);
    interval_req_t r;
    int            f;
    int            l;
    int            roll;
    roll = noisy ? $urandom_range(99) : 99;
    r.kind = KIND_ALLOC;
    r.thread = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
    case (m)
      BURST_WIDE: begin
        f = $urandom_range(8);
        l = $urandom_range(31, 20);
      end
      BURST_ORDERED: begin
        stage_cursor += $urandom_range(2);
        if (stage_cursor > 31) stage_cursor = 0;
        f = stage_cursor;
        l = f + $urandom_range(6);
        if (l > 31) l = 31;
      end
      BURST_SHORT: begin
        f = $urandom_range(31);
        l = (f == 31) ? 31 : f + $urandom_range(1);
      end
      default: begin
        f = $urandom_range(31);
        l = $urandom_range(31);
      end
    endcase
    if (roll < 4) begin
      f = $urandom_range(31, 1);
      l = $urandom_range(f - 1);
    end else if (roll < 7) begin
      r.kind = KIND_CLEAR;
    end
    r.first_stg = 5'(f);
    r.last_stg = 5'(l);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Accepted beats on both channels, seen at the rising edge.
  always @(posedge clk_i) begin
    alloc_res_t    e;
    interval_req_t r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_allocs.size() == 0) begin
          note_mismatch("unexpected result beat, status", status_o, -1);
        end else begin
          e = expected_allocs.pop_front();
          if (tag_o !== e.tag) note_mismatch("tag", tag_o, e.tag);
          if (status_o !== e.status) note_mismatch("status", status_o, e.status);
          if (tag_count_o !== e.count) note_mismatch("tag_count", tag_count_o, e.count);
          if (over_limit_o !== e.over) note_mismatch("over_limit", over_limit_o, e.over);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        r = '{kind_i, first_stage_i, last_stage_i, thread_id_i};
        e = first_fit(r);
        if (drv_fixed) e = drv_want;
        expected_allocs = {expected_allocs, e};
      end
    end
  end

  // Result side: random stall, or a long hold counted down here.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[interval_tag_first_fit_allocator_unit] ERROR");
    $finish;
  end

  task automatic offer_beat(input interval_req_t r, input logic fixed, input alloc_res_t want,
                            input int idle_pct);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= r.kind;
    first_stage_i <= r.first_stg;
    last_stage_i <= r.last_stg;
    thread_id_i <= r.thread;
    drv_fixed <= fixed;
    drv_want <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk_i);
  endtask

  // Write tag_limit with noise in the unused bits, then read it back.
  task automatic write_tag_limit(input logic [4:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(REG_TAG_LIMIT) << 2;
    pwdata <= DATA_W'({$urandom, value});
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_limit = value;
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[LIMIT_W-1:0] !== value) note_mismatch("tag_limit readback", prdata, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int            send_idle [5];
    int            recv_stall[5];
    logic [4:0]    limits    [5];
    int            p;
    int            sent;
    int            left;
    int            burst_no;
    burst_e        mode;
    bit            noisy;
    interval_req_t clear_req;

    send_idle = '{0, 82, 0, 10, 0};
    recv_stall = '{0, 0, 82, 10, 0};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_ALLOC;
    first_stage_i = '0;
    last_stage_i = '0;
    thread_id_i = '0;
    drv_fixed = 1'b0;
    drv_want = NO_WANT;
    mismatches = 0;
    stall_pct = 0;
    hold_left = 0;
    stage_cursor = 0;
    shadow_count = 0;
    shadow_tags = 0;
    shadow_limit = TAG_LIMIT_RESET;
    limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'($urandom_range(16, 1))};
    clear_req = '{KIND_CLEAR, 5'd0, 5'd0, 2'd0};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Hand-picked intervals under the reset tag_limit.
    foreach (plan[i]) offer_beat(plan[i].req, plan[i].fixed, plan[i].want, 0);

    burst_no = 0;
    left = 0;
    mode = BURST_MIXED;
    noisy = 1'b1;
    for (p = 0; p < 5; p++) begin
      wait_drained();
      write_tag_limit(limits[p]);
      stall_pct = recv_stall[p];
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if (left == 0) begin
          // The first two bursts run the tag pool dry, then the store.
          if (burst_no == 0) begin
            mode = BURST_WIDE;
            left = 20;
            noisy = 1'b0;
          end else if (burst_no == 1) begin
            mode = BURST_SHORT;
            left = 70;
            noisy = 1'b0;
          end else begin
            mode = burst_e'($urandom_range(3));
            left = ($urandom_range(3) == 0) ? $urandom_range(80, 66) : $urandom_range(30, 5);
            noisy = 1'b1;
          end
          if (burst_no < 2 || $urandom_range(2) != 0) begin
            offer_beat(clear_req, 1'b0, NO_WANT, send_idle[p]);
            sent++;
          end
          burst_no++;
        end
        offer_beat(make_interval(mode, noisy), 1'b0, NO_WANT, send_idle[p]);
        sent++;
        left--;
        if (p == 3 && sent == 40) hold_left = 400;
        if (p == 3 && sent == 90) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[interval_tag_first_fit_allocator_unit] OK");
    end else begin
      $display("[interval_tag_first_fit_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/itffa_pkg.sv
sv/interval_tag_first_fit_allocator_unit.sv
sv/itffa_checker.sv
bench/tb_interval_tag_first_fit_allocator_unit.sv
